// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, suspended while reset is high.
`define MBE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, including while reset is high.
`define MBE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mbe_pkg.sv =====
// Package with the types and constants of the escape-time core.
package mbe_pkg;

   localparam int IMAGE_WIDTH_DEFAULT  = 1024;
   localparam int IMAGE_HEIGHT_DEFAULT = 1024;

   localparam int COORD_WIDTH = 10;
   localparam int COUNT_WIDTH = 11;
   localparam int GRAY_WIDTH  = 8;
   localparam int Q_WIDTH     = 32;
   localparam int STEP_WIDTH  = 31;
   localparam int PROD_WIDTH  = 64;
   localparam int FRAC_BITS   = 28;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [COUNT_WIDTH-1:0] LIMIT_MAX = 11'd1024;
   localparam logic [COUNT_WIDTH-1:0] LIMIT_MIN = 11'd1;
   localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = 11'd256;
   localparam logic signed [Q_WIDTH-1:0] REAL_ORIGIN_RESET = -32'sd671088640;
   localparam logic signed [Q_WIDTH-1:0] IMAG_ORIGIN_RESET = -32'sd536870912;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_REAL_ORIGIN     = 3'd0,
      CSR_REAL_STEP       = 3'd1,
      CSR_IMAG_ORIGIN     = 3'd2,
      CSR_IMAG_STEP       = 3'd3,
      CSR_ITERATION_LIMIT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] pixel_x;
      logic [COORD_WIDTH-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] iteration_count;
      logic [GRAY_WIDTH-1:0]  gray_level;
      logic [COORD_WIDTH-1:0] out_x;
      logic [COORD_WIDTH-1:0] out_y;
   } rsp_type;

   typedef struct packed {
      logic signed [Q_WIDTH-1:0] real_origin;
      logic [STEP_WIDTH-1:0]     real_step;
      logic signed [Q_WIDTH-1:0] imag_origin;
      logic [STEP_WIDTH-1:0]     imag_step;
      logic [COUNT_WIDTH-1:0]    iteration_limit;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_R,
      ST_MAP_I,
      ST_MAP_END,
      ST_PRODUCT,
      ST_UPDATE,
      ST_SQUARE_R,
      ST_SQUARE_I,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_MAP_R,
      MUL_MAP_I,
      MUL_CROSS,
      MUL_SQUARE_R,
      MUL_SQUARE_I
   } mul_sel_type;

   typedef struct packed {
      logic        start;
      mul_sel_type mul_sel;
      logic        cr_load;
      logic        ci_load;
      logic        z_update;
      logic        out_load;
   } dp_ctrl_type;

   typedef struct packed {
      logic finished;
   } dp_status_type;

endpackage

// ===== rtl/core/mbe_csr.sv =====
// Configuration register bank of the escape-time core.
module mbe_csr #(
   parameter int IMAGE_WIDTH  = mbe_pkg::IMAGE_WIDTH_DEFAULT,
   parameter int IMAGE_HEIGHT = mbe_pkg::IMAGE_HEIGHT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mbe_pkg::Q_WIDTH-1:0]         csr_data,
   output mbe_pkg::cfg_type                    cfg
);

   localparam logic [mbe_pkg::STEP_WIDTH-1:0] RealStepReset =
      mbe_pkg::STEP_WIDTH'((64'd1 << 30) / IMAGE_WIDTH);
   localparam logic [mbe_pkg::STEP_WIDTH-1:0] ImagStepReset =
      mbe_pkg::STEP_WIDTH'((64'd1 << 30) / IMAGE_HEIGHT);

   mbe_pkg::cfg_type cfg_ff;
   mbe_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (mbe_pkg::csr_index_type'(csr_index))
            mbe_pkg::CSR_REAL_ORIGIN: begin
               cfg_in.real_origin = csr_data;
            end
            mbe_pkg::CSR_REAL_STEP: begin
               cfg_in.real_step = csr_data[mbe_pkg::STEP_WIDTH-1:0];
            end
            mbe_pkg::CSR_IMAG_ORIGIN: begin
               cfg_in.imag_origin = csr_data;
            end
            mbe_pkg::CSR_IMAG_STEP: begin
               cfg_in.imag_step = csr_data[mbe_pkg::STEP_WIDTH-1:0];
            end
            mbe_pkg::CSR_ITERATION_LIMIT: begin
               cfg_in.iteration_limit = csr_data[mbe_pkg::COUNT_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.real_origin     <= mbe_pkg::REAL_ORIGIN_RESET;
         cfg_ff.real_step       <= RealStepReset;
         cfg_ff.imag_origin     <= mbe_pkg::IMAG_ORIGIN_RESET;
         cfg_ff.imag_step       <= ImagStepReset;
         cfg_ff.iteration_limit <= mbe_pkg::LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/mbe_datapath.sv =====
// Datapath with the shared multiplier, the iteration registers and the result register.
module mbe_datapath (
   input  logic                  clock,
   input  mbe_pkg::req_type      req_data,
   input  mbe_pkg::cfg_type      cfg,
   input  mbe_pkg::dp_ctrl_type  ctrl,
   output mbe_pkg::dp_status_type status,
   output mbe_pkg::rsp_type      rsp_data
);

   localparam logic signed [mbe_pkg::PROD_WIDTH-1:0] QMax = 64'sd2147483647;
   localparam logic signed [mbe_pkg::PROD_WIDTH-1:0] QMin = -64'sd2147483648;

   function automatic logic signed [mbe_pkg::Q_WIDTH-1:0] sat_q(
      input logic signed [mbe_pkg::PROD_WIDTH-1:0] v);
      logic signed [mbe_pkg::Q_WIDTH-1:0] r;
      if (v > QMax) begin
         r = QMax[mbe_pkg::Q_WIDTH-1:0];
      end else if (v < QMin) begin
         r = QMin[mbe_pkg::Q_WIDTH-1:0];
      end else begin
         r = v[mbe_pkg::Q_WIDTH-1:0];
      end
      return r;
   endfunction

   logic [mbe_pkg::COORD_WIDTH-1:0]        px_ff;
   logic [mbe_pkg::COORD_WIDTH-1:0]        py_ff;
   logic [mbe_pkg::COUNT_WIDTH-1:0]        limit_ff;
   logic [mbe_pkg::COUNT_WIDTH-1:0]        limit_in;
   logic [mbe_pkg::COUNT_WIDTH-1:0]        count_ff;
   logic signed [mbe_pkg::Q_WIDTH-1:0]     cr_ff;
   logic signed [mbe_pkg::Q_WIDTH-1:0]     ci_ff;
   logic signed [mbe_pkg::Q_WIDTH-1:0]     zr_ff;
   logic signed [mbe_pkg::Q_WIDTH-1:0]     zi_ff;
   logic signed [mbe_pkg::PROD_WIDTH-1:0]  prod_ff;
   logic signed [mbe_pkg::PROD_WIDTH-1:0]  sr_ff;
   logic signed [mbe_pkg::PROD_WIDTH-1:0]  si_ff;
   logic signed [mbe_pkg::Q_WIDTH-1:0]     mul_a;
   logic signed [mbe_pkg::Q_WIDTH-1:0]     mul_b;
   logic signed [mbe_pkg::PROD_WIDTH-1:0]  mul_res;
   logic signed [mbe_pkg::PROD_WIDTH-1:0]  diff;
   logic signed [mbe_pkg::Q_WIDTH-1:0]     nr;
   logic signed [mbe_pkg::Q_WIDTH-1:0]     ni;
   logic [mbe_pkg::PROD_WIDTH-1:0]         mag;
   logic                                   escaped;
   mbe_pkg::rsp_type                       rsp_ff;

   always_comb begin
      limit_in = cfg.iteration_limit;
      if (limit_in < mbe_pkg::LIMIT_MIN) begin
         limit_in = mbe_pkg::LIMIT_MIN;
      end else if (limit_in > mbe_pkg::LIMIT_MAX) begin
         limit_in = mbe_pkg::LIMIT_MAX;
      end
   end

   always_comb begin
      case (ctrl.mul_sel)
         mbe_pkg::MUL_MAP_R: begin
            mul_a = signed'(mbe_pkg::Q_WIDTH'(px_ff));
            mul_b = signed'(mbe_pkg::Q_WIDTH'(cfg.real_step));
         end
         mbe_pkg::MUL_MAP_I: begin
            mul_a = signed'(mbe_pkg::Q_WIDTH'(py_ff));
            mul_b = signed'(mbe_pkg::Q_WIDTH'(cfg.imag_step));
         end
         mbe_pkg::MUL_CROSS: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
         mbe_pkg::MUL_SQUARE_R: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         mbe_pkg::MUL_SQUARE_I: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_res = mbe_pkg::PROD_WIDTH'(mul_a) * mbe_pkg::PROD_WIDTH'(mul_b);

   assign diff = sr_ff - si_ff;
   assign nr   = sat_q((diff >>> mbe_pkg::FRAC_BITS) + mbe_pkg::PROD_WIDTH'(cr_ff));
   assign ni   = sat_q((prod_ff >>> (mbe_pkg::FRAC_BITS - 1)) +
                       mbe_pkg::PROD_WIDTH'(ci_ff));

   // Squares of the latest z are kept, so the escape test and the next real part share them.
   assign mag     = unsigned'(sr_ff) + unsigned'(si_ff);
   assign escaped = |mag[mbe_pkg::PROD_WIDTH-1:58];

   assign status.finished = escaped || (count_ff == limit_ff);
   assign rsp_data        = rsp_ff;

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         px_ff    <= req_data.pixel_x;
         py_ff    <= req_data.pixel_y;
         limit_ff <= limit_in;
         count_ff <= '0;
         zr_ff    <= '0;
         zi_ff    <= '0;
         sr_ff    <= '0;
         si_ff    <= '0;
      end else begin
         if (ctrl.z_update) begin
            zr_ff    <= nr;
            zi_ff    <= ni;
            count_ff <= count_ff + 1'b1;
         end
         if (ctrl.mul_sel == mbe_pkg::MUL_SQUARE_R) begin
            sr_ff <= mul_res;
         end
         if (ctrl.mul_sel == mbe_pkg::MUL_SQUARE_I) begin
            si_ff <= mul_res;
         end
      end
      if (ctrl.mul_sel == mbe_pkg::MUL_MAP_R || ctrl.mul_sel == mbe_pkg::MUL_MAP_I ||
          ctrl.mul_sel == mbe_pkg::MUL_CROSS) begin
         prod_ff <= mul_res;
      end
      if (ctrl.cr_load) begin
         cr_ff <= sat_q(mbe_pkg::PROD_WIDTH'(cfg.real_origin) + prod_ff);
      end
      if (ctrl.ci_load) begin
         ci_ff <= sat_q(mbe_pkg::PROD_WIDTH'(cfg.imag_origin) + prod_ff);
      end
      if (ctrl.out_load) begin
         rsp_ff.iteration_count <= count_ff;
         rsp_ff.gray_level      <= count_ff[mbe_pkg::GRAY_WIDTH-1:0];
         rsp_ff.out_x           <= px_ff;
         rsp_ff.out_y           <= py_ff;
      end
   end

endmodule

// ===== rtl/core/mbe_ctrl.sv =====
// Sequencer that steps the shared multiplier through mapping and iterations.
module mbe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mbe_pkg::dp_status_type status,
   output mbe_pkg::dp_ctrl_type   ctrl
);

   mbe_pkg::state_type state_ff;
   mbe_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mbe_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = mbe_pkg::ST_MAP_R;
            end
         end
         mbe_pkg::ST_MAP_R: begin
            state_in = mbe_pkg::ST_MAP_I;
         end
         mbe_pkg::ST_MAP_I: begin
            state_in = mbe_pkg::ST_MAP_END;
         end
         mbe_pkg::ST_MAP_END: begin
            state_in = mbe_pkg::ST_PRODUCT;
         end
         mbe_pkg::ST_PRODUCT: begin
            state_in = status.finished ? mbe_pkg::ST_DONE : mbe_pkg::ST_UPDATE;
         end
         mbe_pkg::ST_UPDATE: begin
            state_in = mbe_pkg::ST_SQUARE_R;
         end
         mbe_pkg::ST_SQUARE_R: begin
            state_in = mbe_pkg::ST_SQUARE_I;
         end
         mbe_pkg::ST_SQUARE_I: begin
            state_in = mbe_pkg::ST_PRODUCT;
         end
         mbe_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = mbe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mbe_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      ctrl.start    = 1'b0;
      ctrl.mul_sel  = mbe_pkg::MUL_NONE;
      ctrl.cr_load  = 1'b0;
      ctrl.ci_load  = 1'b0;
      ctrl.z_update = 1'b0;
      ctrl.out_load = 1'b0;
      case (state_ff)
         mbe_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            ctrl.start = req_valid;
         end
         mbe_pkg::ST_MAP_R: begin
            ctrl.mul_sel = mbe_pkg::MUL_MAP_R;
         end
         mbe_pkg::ST_MAP_I: begin
            ctrl.mul_sel = mbe_pkg::MUL_MAP_I;
            ctrl.cr_load = 1'b1;
         end
         mbe_pkg::ST_MAP_END: begin
            ctrl.ci_load = 1'b1;
         end
         mbe_pkg::ST_PRODUCT: begin
            ctrl.mul_sel = mbe_pkg::MUL_CROSS;
         end
         mbe_pkg::ST_UPDATE: begin
            ctrl.z_update = 1'b1;
         end
         mbe_pkg::ST_SQUARE_R: begin
            ctrl.mul_sel = mbe_pkg::MUL_SQUARE_R;
         end
         mbe_pkg::ST_SQUARE_I: begin
            ctrl.mul_sel = mbe_pkg::MUL_SQUARE_I;
         end
         mbe_pkg::ST_DONE: begin
            ctrl.out_load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/mandelbrot_escape_time_core.sv =====
// Top level of the Mandelbrot escape-time core.
// The req channel takes one beat per pixel (pixel_x, pixel_y); each beat is mapped to
// c = origin + coordinate * step and iterated with z = z*z + c from zero until
// |z|^2 reaches 4 or the iteration limit is hit. The rsp channel returns one beat per
// pixel with the iteration count, the gray level (count modulo 256) and the coordinates.
// The csr channel writes origins, steps and the iteration limit by index; it is always
// ready and should only be written while no pixel is in flight.
// One 32x32 multiplier is shared by every product, so an iteration steps through the
// cross product, the update and the two squares in turn. When a result is loaded into
// the output register, rsp_valid rises and req_ready returns in the same cycle; a new
// pixel is taken only after the last one has been computed, not during its iterations.
// The result sits in an output register; if the receiver stalls, the next pixel is
// still accepted and computed, and the core waits only when it has a second result
// ready. A synchronous reset returns the core to idle, drops rsp_valid and loads the
// default view (-2.5 - 2.0i origin, 4.0 / image size step, limit 256).
module mandelbrot_escape_time_core #(
   parameter int IMAGE_WIDTH  = mbe_pkg::IMAGE_WIDTH_DEFAULT,
   parameter int IMAGE_HEIGHT = mbe_pkg::IMAGE_HEIGHT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mbe_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mbe_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mbe_pkg::Q_WIDTH-1:0]         csr_data
);

   mbe_pkg::cfg_type       cfg;
   mbe_pkg::dp_ctrl_type   ctrl;
   mbe_pkg::dp_status_type status;

   mbe_csr #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   mbe_datapath u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cfg      (cfg),
      .ctrl     (ctrl),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/core/mbe_checker.sv =====
// Port-level assertions for the escape-time core and their binding.
`include "assert_macros.svh"

module mbe_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mbe_pkg::rsp_type rsp_data
);

   `MBE_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready, "Reset did not return the core to idle.")
   `MBE_ASSERT(a_busy_after_req, clock, reset, req_valid && req_ready |=> !req_ready, "The core took a beat while busy.")
   `MBE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "A stalled rsp beat changed.")
   `MBE_ASSERT(a_rsp_fields, clock, reset, rsp_valid |-> rsp_data.gray_level == rsp_data.iteration_count[7:0] && rsp_data.iteration_count != 11'd0 && rsp_data.iteration_count <= mbe_pkg::LIMIT_MAX, "The rsp beat holds an impossible count.")

endmodule

bind mandelbrot_escape_time_core mbe_checker u_mbe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
